>>> rtl/itaf_pkg.sv
// Shared types, codes and character constants for the integer-to-ASCII formatter.
package itaf_pkg;

  // base_sel codes; any other code formats as hexadecimal
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] LC_MASK  = 8'h20;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CONV,
    S_NORM,
    S_SETUP,
    S_LEAD,
    S_SIGN,
    S_PFX0,
    S_PFXX,
    S_ZERO,
    S_DIG,
    S_TRAIL
  } state_e;

  // which text segment a character belongs to
  typedef enum logic [2:0] {
    SEL_LEAD,
    SEL_SIGN,
    SEL_PFX0,
    SEL_PFXX,
    SEL_ZERO,
    SEL_DIG,
    SEL_TRAIL
  } chr_sel_e;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     conv_step;
    logic     norm_step;
    logic     setup;
    logic     emit;
    logic     last;
    chr_sel_e sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic       is_dec;
    logic       conv_done;
    logic       norm_done;
    logic       has_sign;
    logic [1:0] pfx_len;
    logic       lead_nz;
    logic       lead_one;
    logic       zero_nz;
    logic       zero_one;
    logic       dig_one;
    logic       trail_nz;
    logic       trail_one;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return HEX_DIGITS[d];
  endfunction

endpackage

>>> rtl/itaf_dp.sv
// Datapath: magnitude, digit conversion, segment counters and output register.
module itaf_dp #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 60
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  itaf_pkg::ctl_cmd_t     cmd_i,
  output itaf_pkg::dp_sts_t      sts_o,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  logic [1:0]             base_sel_i,
  input  logic [5:0]             text_width_i,
  input  logic [5:0]             min_digits_i,
  input  logic                   left_justify_i,
  input  logic                   zero_pad_i,
  input  logic                   show_plus_i,
  input  logic                   space_sign_i,
  input  logic                   alt_prefix_i,
  input  logic                   lower_case_i,
  input  logic                   is_signed_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_char_o,
  output logic                   last_char_o
);

  localparam int ND  = (VALUE_BITS + 2) / 3;   // octal digits, covers every base
  localparam int NH  = (VALUE_BITS + 3) / 4;
  localparam int DCW = $clog2(ND + 1);
  localparam int CW  = $clog2(MAX_FIELD + 1);
  localparam int CNW = $clog2(VALUE_BITS);
  localparam int SW  = ((CW > DCW) ? CW : DCW) + 2;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [4*ND-1:0]       digits_q, digits_d;
  logic [CNW-1:0]        conv_cnt_q, conv_cnt_d;
  logic [DCW-1:0]        dig_cnt_q, dig_cnt_d;
  logic [CW-1:0]         width_q, width_d;
  logic [CW-1:0]         prec_q, prec_d;
  logic                  left_q, left_d;
  logic                  zpad_q, zpad_d;
  logic                  has_sign_q, has_sign_d;
  logic [7:0]            sign_char_q, sign_char_d;
  logic [1:0]            pfx_len_q, pfx_len_d;
  logic                  is_dec_q, is_dec_d;
  logic                  is_hex_q, is_hex_d;
  logic [7:0]            lc_q, lc_d;
  logic [CW-1:0]         lead_cnt_q, lead_cnt_d;
  logic [CW-1:0]         zero_cnt_q, zero_cnt_d;
  logic [CW-1:0]         trail_cnt_q, trail_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [3*ND-1:0] oct_src;
  logic [4*NH-1:0] hex_src;
  logic [4*ND-1:0] oct_lanes, hex_lanes, dab_lanes;
  logic [3:0]      top_dig;
  logic            neg;
  logic            out_free;
  logic [SW-1:0]   prec_s, pad_s, pad_pos, pz_s, zp_s;
  logic [7:0]      chr;

  assign oct_src = (3*ND)'(mag_q);
  assign hex_src = (4*NH)'(mag_q);
  // hex nibbles already sit in lane order; upper lanes are zero
  assign hex_lanes = (4*ND)'(hex_src);
  assign top_dig = digits_q[4*ND-1 -: 4];
  assign neg     = is_signed_i & value_i[VALUE_BITS-1];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      oct_lanes[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
      // shift-add-3 correction per decimal digit
      dab_lanes[4*i +: 4] = (digits_q[4*i +: 4] >= 4'd5) ? digits_q[4*i +: 4] + 4'd3
                                                         : digits_q[4*i +: 4];
    end
  end

  // padding arithmetic; the sign bit of pad_s flags a negative pad
  always_comb begin
    prec_s  = (SW'(prec_q) > SW'(dig_cnt_q)) ? SW'(prec_q) : SW'(dig_cnt_q);
    pad_s   = SW'(width_q) - SW'(has_sign_q) - SW'(pfx_len_q) - prec_s;
    pad_pos = pad_s[SW-1] ? '0 : pad_s;
    pz_s    = prec_s - SW'(dig_cnt_q);
    zp_s    = (zpad_q && !left_q) ? pad_pos : '0;
  end

  always_comb begin
    unique case (cmd_i.sel)
      itaf_pkg::SEL_LEAD:  chr = itaf_pkg::CH_SPACE;
      itaf_pkg::SEL_SIGN:  chr = sign_char_q;
      itaf_pkg::SEL_PFX0:  chr = itaf_pkg::CH_ZERO;
      itaf_pkg::SEL_PFXX:  chr = itaf_pkg::CH_X | lc_q;
      itaf_pkg::SEL_ZERO:  chr = itaf_pkg::CH_ZERO;
      itaf_pkg::SEL_DIG:   chr = itaf_pkg::hex_char(top_dig) | lc_q;
      itaf_pkg::SEL_TRAIL: chr = itaf_pkg::CH_SPACE;
      default:             chr = itaf_pkg::CH_SPACE;
    endcase
  end

  always_comb begin
    mag_d       = mag_q;
    digits_d    = digits_q;
    conv_cnt_d  = conv_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    width_d     = width_q;
    prec_d      = prec_q;
    left_d      = left_q;
    zpad_d      = zpad_q;
    has_sign_d  = has_sign_q;
    sign_char_d = sign_char_q;
    pfx_len_d   = pfx_len_q;
    is_dec_d    = is_dec_q;
    is_hex_d    = is_hex_q;
    lc_d        = lc_q;
    lead_cnt_d  = lead_cnt_q;
    zero_cnt_d  = zero_cnt_q;
    trail_cnt_d = trail_cnt_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (cmd_i.load) begin
      mag_d      = neg ? (~value_i + 1'b1) : value_i;
      has_sign_d = is_signed_i & (neg | show_plus_i | space_sign_i);
      if (neg) begin
        sign_char_d = itaf_pkg::CH_MINUS;
      end else if (show_plus_i) begin
        sign_char_d = itaf_pkg::CH_PLUS;
      end else begin
        sign_char_d = itaf_pkg::CH_SPACE;
      end
      is_dec_d  = (base_sel_i == itaf_pkg::BASE_DEC);
      is_hex_d  = (base_sel_i != itaf_pkg::BASE_DEC) && (base_sel_i != itaf_pkg::BASE_OCT);
      pfx_len_d = !alt_prefix_i ? 2'd0 :
                  (base_sel_i == itaf_pkg::BASE_OCT) ? 2'd1 :
                  (base_sel_i == itaf_pkg::BASE_DEC) ? 2'd0 : 2'd2;
      width_d = (text_width_i > 6'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(text_width_i);
      prec_d  = (min_digits_i > 6'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(min_digits_i);
      left_d  = left_justify_i;
      zpad_d  = zero_pad_i & ~left_justify_i;
      lc_d    = lower_case_i ? itaf_pkg::LC_MASK : 8'h00;
    end

    if (cmd_i.prep) begin
      dig_cnt_d  = DCW'(ND);
      conv_cnt_d = '0;
      if (is_dec_q) begin
        digits_d = '0;
      end else if (is_hex_q) begin
        digits_d = hex_lanes;
      end else begin
        digits_d = oct_lanes;
      end
    end

    if (cmd_i.conv_step) begin
      digits_d   = {dab_lanes[4*ND-2:0], mag_q[VALUE_BITS-1]};
      mag_d      = mag_q << 1;
      conv_cnt_d = conv_cnt_q + 1'b1;
    end

    // drop leading zero digits so the top lane is the first to print
    if (cmd_i.norm_step) begin
      digits_d  = digits_q << 4;
      dig_cnt_d = dig_cnt_q - 1'b1;
    end

    if (cmd_i.setup) begin
      lead_cnt_d  = (!zpad_q && !left_q) ? CW'(pad_pos) : '0;
      zero_cnt_d  = CW'(zp_s + pz_s);
      trail_cnt_d = left_q ? CW'(pad_pos) : '0;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = chr;
      out_last_d  = cmd_i.last;
      unique case (cmd_i.sel)
        itaf_pkg::SEL_LEAD:  lead_cnt_d  = lead_cnt_q - 1'b1;
        itaf_pkg::SEL_ZERO:  zero_cnt_d  = zero_cnt_q - 1'b1;
        itaf_pkg::SEL_TRAIL: trail_cnt_d = trail_cnt_q - 1'b1;
        itaf_pkg::SEL_DIG: begin
          digits_d  = digits_q << 4;
          dig_cnt_d = dig_cnt_q - 1'b1;
        end
        default: ;
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    digits_q    <= digits_d;
    conv_cnt_q  <= conv_cnt_d;
    dig_cnt_q   <= dig_cnt_d;
    width_q     <= width_d;
    prec_q      <= prec_d;
    left_q      <= left_d;
    zpad_q      <= zpad_d;
    has_sign_q  <= has_sign_d;
    sign_char_q <= sign_char_d;
    pfx_len_q   <= pfx_len_d;
    is_dec_q    <= is_dec_d;
    is_hex_q    <= is_hex_d;
    lc_q        <= lc_d;
    lead_cnt_q  <= lead_cnt_d;
    zero_cnt_q  <= zero_cnt_d;
    trail_cnt_q <= trail_cnt_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    sts_o.is_dec    = is_dec_q;
    sts_o.conv_done = (conv_cnt_q == CNW'(VALUE_BITS - 1));
    sts_o.norm_done = (dig_cnt_q == DCW'(1)) || (top_dig != 4'd0);
    sts_o.has_sign  = has_sign_q;
    sts_o.pfx_len   = pfx_len_q;
    sts_o.lead_nz   = (lead_cnt_q != '0);
    sts_o.lead_one  = (lead_cnt_q == CW'(1));
    sts_o.zero_nz   = (zero_cnt_q != '0);
    sts_o.zero_one  = (zero_cnt_q == CW'(1));
    sts_o.dig_one   = (dig_cnt_q == DCW'(1));
    sts_o.trail_nz  = (trail_cnt_q != '0);
    sts_o.trail_one = (trail_cnt_q == CW'(1));
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

>>> rtl/itaf_ctrl.sv
// Controller: sequences load, conversion, normalization and the text segments.
module itaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itaf_pkg::dp_sts_t   sts_i,
  output itaf_pkg::ctl_cmd_t  cmd_o
);

  itaf_pkg::state_e state_q, state_d;

  // first nonempty segment from the given point onward
  function automatic itaf_pkg::state_e from_zero(input itaf_pkg::dp_sts_t st);
    return st.zero_nz ? itaf_pkg::S_ZERO : itaf_pkg::S_DIG;
  endfunction

  function automatic itaf_pkg::state_e from_pfx0(input itaf_pkg::dp_sts_t st);
    return (st.pfx_len != 2'd0) ? itaf_pkg::S_PFX0 : from_zero(st);
  endfunction

  function automatic itaf_pkg::state_e from_sign(input itaf_pkg::dp_sts_t st);
    return st.has_sign ? itaf_pkg::S_SIGN : from_pfx0(st);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itaf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.sel       = itaf_pkg::SEL_DIG;
    in_stall_o      = (state_q != itaf_pkg::S_IDLE);

    unique case (state_q)
      itaf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = itaf_pkg::S_PREP;
        end
      end
      itaf_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.is_dec ? itaf_pkg::S_CONV : itaf_pkg::S_NORM;
      end
      itaf_pkg::S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) state_d = itaf_pkg::S_NORM;
      end
      itaf_pkg::S_NORM: begin
        if (sts_i.norm_done) begin
          state_d = itaf_pkg::S_SETUP;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      itaf_pkg::S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = itaf_pkg::S_LEAD;
      end
      itaf_pkg::S_LEAD: begin
        cmd_o.sel = itaf_pkg::SEL_LEAD;
        if (!sts_i.lead_nz) begin
          state_d = from_sign(sts_i);
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.lead_one) state_d = from_sign(sts_i);
        end
      end
      itaf_pkg::S_SIGN: begin
        cmd_o.sel = itaf_pkg::SEL_SIGN;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = from_pfx0(sts_i);
        end
      end
      itaf_pkg::S_PFX0: begin
        cmd_o.sel = itaf_pkg::SEL_PFX0;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = (sts_i.pfx_len == 2'd2) ? itaf_pkg::S_PFXX : from_zero(sts_i);
        end
      end
      itaf_pkg::S_PFXX: begin
        cmd_o.sel = itaf_pkg::SEL_PFXX;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = from_zero(sts_i);
        end
      end
      itaf_pkg::S_ZERO: begin
        cmd_o.sel = itaf_pkg::SEL_ZERO;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.zero_one) state_d = itaf_pkg::S_DIG;
        end
      end
      itaf_pkg::S_DIG: begin
        cmd_o.sel = itaf_pkg::SEL_DIG;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = sts_i.dig_one & ~sts_i.trail_nz;
          if (sts_i.dig_one) begin
            state_d = sts_i.trail_nz ? itaf_pkg::S_TRAIL : itaf_pkg::S_IDLE;
          end
        end
      end
      itaf_pkg::S_TRAIL: begin
        cmd_o.sel = itaf_pkg::SEL_TRAIL;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = sts_i.trail_one;
          if (sts_i.trail_one) state_d = itaf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = itaf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// Top level of the printf-style integer-to-ASCII formatter.
// Takes one value with its format options per item and returns the text one
// character per output item, last_char_o marking the final one. One item at a
// time is in work: the next is taken once the last character of the previous
// one sits in the output register. An item goes through load, preparation,
// shift-add-3 conversion for decimal (one bit per cycle), a scan that drops
// leading zero digits, setup of the segment counters and then the text, which
// waits while the output side stalls. Octal and hex skip the conversion loop.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 60
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [1:0]            base_sel_i,
  input  logic [5:0]            text_width_i,
  input  logic [5:0]            min_digits_i,
  input  logic                  left_justify_i,
  input  logic                  zero_pad_i,
  input  logic                  show_plus_i,
  input  logic                  space_sign_i,
  input  logic                  alt_prefix_i,
  input  logic                  lower_case_i,
  input  logic                  is_signed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_char_o,
  output logic                  last_char_o
);

  itaf_pkg::ctl_cmd_t cmd;
  itaf_pkg::dp_sts_t  sts;

  itaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itaf_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .base_sel_i     (base_sel_i),
    .text_width_i   (text_width_i),
    .min_digits_i   (min_digits_i),
    .left_justify_i (left_justify_i),
    .zero_pad_i     (zero_pad_i),
    .show_plus_i    (show_plus_i),
    .space_sign_i   (space_sign_i),
    .alt_prefix_i   (alt_prefix_i),
    .lower_case_i   (lower_case_i),
    .is_signed_i    (is_signed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .last_char_o    (last_char_o)
  );

  // a character is only written into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("character written into an occupied output register");

  // the last character comes from the digits or the trailing spaces
  a_last_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.last |-> cmd.emit && (cmd.sel == itaf_pkg::SEL_DIG || cmd.sel == itaf_pkg::SEL_TRAIL))
    else $error("last flag outside the final segment");

  // after the final character the block takes a new item at once
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && cmd.last |=> !in_stall_o)
    else $error("not ready after the final character");

  // a freshly accepted item emits nothing before its conversion
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cmd.emit)
    else $error("character emitted right after accept");

endmodule
